FILE: sv/qfid_pkg.sv
// shared types, codeword table and helpers for the format information decoder
package qfid_pkg;

    localparam int unsigned WORD_W    = 15;
    localparam int unsigned ENTRIES   = 32;
    localparam int unsigned IDX_W     = $clog2(ENTRIES);
    localparam int unsigned DIST_W    = 2;
    localparam int unsigned POP_W     = $clog2(WORD_W + 1);
    localparam logic [WORD_W-1:0] XOR_MASK = 15'h5412;
    localparam logic [POP_W-1:0]  MAX_DIST = POP_W'(3);

    typedef logic [WORD_W-1:0] fmt_word_t;

    // masked bch(15,5) codewords, index is the 5-bit decoded value
    localparam fmt_word_t CODEWORDS [ENTRIES] = '{
        15'h5412, 15'h5125, 15'h5E7C, 15'h5B4B, 15'h45F9, 15'h40CE, 15'h4F97, 15'h4AA0,
        15'h77C4, 15'h72F3, 15'h7DAA, 15'h789D, 15'h662F, 15'h6318, 15'h6C41, 15'h6976,
        15'h1689, 15'h13BE, 15'h1CE7, 15'h19D0, 15'h0762, 15'h0255, 15'h0D0C, 15'h083B,
        15'h355F, 15'h3068, 15'h3F31, 15'h3A06, 15'h24B4, 15'h2183, 15'h2EDA, 15'h2BED
    };

    // nearest codeword within the distance limit for one reading
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [DIST_W-1:0] distance;
    } qfid_cand_t;

    function automatic logic [POP_W-1:0] pop15(input fmt_word_t v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            n = n + POP_W'(v[b]);
        end
        return n;
    endfunction

endpackage

FILE: sv/qfid_match.sv
// finds the one codeword within distance 3 of a single reading, if any
module qfid_match
    import qfid_pkg::*;
(
    input  fmt_word_t  reading,
    output qfid_cand_t cand
);

    logic [ENTRIES-1:0] near;
    logic [POP_W-1:0]   distance [ENTRIES];

    // codewords are at least 7 apart, so at most one entry can be near
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            distance[i] = pop15(reading ^ CODEWORDS[i]);
            near[i]     = (distance[i] <= MAX_DIST);
        end
    end

    always_comb
    begin
        cand.hit      = |near;
        cand.idx      = '0;
        cand.distance = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            cand.idx      = cand.idx      | (near[i] ? IDX_W'(i) : '0);
            cand.distance = cand.distance | (near[i] ? distance[i][DIST_W-1:0] : '0);
        end
    end

endmodule

FILE: sv/qfid_search.sv
// one search pass over both readings, least distance wins, ties to the lower index
module qfid_search
    import qfid_pkg::*;
(
    input  fmt_word_t  reading_a,
    input  fmt_word_t  reading_b,
    output qfid_cand_t best
);

    qfid_cand_t cand_a;
    qfid_cand_t cand_b;
    logic       take_a;

    qfid_match u_match_a
    (
        .reading (reading_a),
        .cand    (cand_a)
    );

    qfid_match u_match_b
    (
        .reading (reading_b),
        .cand    (cand_b)
    );

    always_comb
    begin
        take_a = cand_a.hit &&
                 (!cand_b.hit || (cand_a.distance < cand_b.distance) ||
                  ((cand_a.distance == cand_b.distance) && (cand_a.idx <= cand_b.idx)));
        best   = take_a ? cand_a : cand_b;
    end

endmodule

FILE: sv/qr_format_info_decoder_unit.sv
// top level of the qr format information decoder
// the accepted input word is held in the input register, then its result word is registered in the result register
// throughput: one word per cycle; the input register and the result register
// form a two stage pipeline that only stalls when out_ready is low
// reset: rst_n asynchronous active low clears both stage valid flags, data
// registers are not reset
module qr_format_info_decoder_unit
    import qfid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WORD_W-1:0]   reading_first,
    input  logic [WORD_W-1:0]   reading_second,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [1:0]          level_code,
    output logic [2:0]          mask_pattern
);

    logic       s1_valid_reg;
    fmt_word_t  reading_first_reg;
    fmt_word_t  reading_second_reg;
    logic       s2_valid_reg;
    logic       found_reg;
    logic [1:0] level_code_reg;
    logic [2:0] mask_pattern_reg;

    logic       s2_load;
    qfid_cand_t pass0;
    qfid_cand_t pass1;
    qfid_cand_t pick;
    logic       found_next;
    logic [1:0] level_code_next;
    logic [2:0] mask_pattern_next;

    assign s2_load  = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_load;

    qfid_search u_pass0
    (
        .reading_a (reading_first_reg),
        .reading_b (reading_second_reg),
        .best      (pass0)
    );

    // second pass on the unmasked readings
    qfid_search u_pass1
    (
        .reading_a (reading_first_reg ^ XOR_MASK),
        .reading_b (reading_second_reg ^ XOR_MASK),
        .best      (pass1)
    );

    always_comb
    begin
        pick              = pass0.hit ? pass0 : pass1;
        found_next        = pick.hit;
        level_code_next   = pick.hit ? pick.idx[IDX_W-1:3] : 2'b00;
        mask_pattern_next = pick.hit ? pick.idx[2:0] : 3'b000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            reading_first_reg  <= reading_first;
            reading_second_reg <= reading_second;
        end
        if (s2_load && s1_valid_reg)
        begin
            found_reg        <= found_next;
            level_code_reg   <= level_code_next;
            mask_pattern_reg <= mask_pattern_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign found        = found_reg;
    assign level_code   = level_code_reg;
    assign mask_pattern = mask_pattern_reg;

    // a miss always reports zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (level_code == 2'b00 && mask_pattern == 3'b000))
        else $error("miss word carries nonzero fields");

    // a held input stage keeps its word while the result stage is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=>
            (s1_valid_reg && $stable(reading_first_reg) && $stable(reading_second_reg)))
        else $error("input stage lost its word during a stall");

    // the second pass only decides when the first one misses
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_load && pass0.hit) |=>
            (found_reg && level_code_reg == $past(pass0.idx[IDX_W-1:3])
             && mask_pattern_reg == $past(pass0.idx[2:0])))
        else $error("first pass hit not taken");

endmodule
